/* rtl/core/kspe_pkg.sv */
// ----------------------------------------------------------------------------
// kspe_pkg
// Shared constants and types for the keyframe spline path evaluator.
// ----------------------------------------------------------------------------
package kspe_pkg;

    localparam int MAX_KEYS   = 16;
    localparam int MIN_KEYS   = 4;
    localparam int KEY_IDX_W  = $clog2(MAX_KEYS);
    localparam int KEY_CNT_W  = KEY_IDX_W + 1;
    localparam int FRAC_BITS  = 16;
    localparam int T_INT_BITS = 8;
    localparam int T_W        = T_INT_BITS + FRAC_BITS + 1;
    localparam int TIME_W     = 32;
    localparam int COORD_W    = 32;
    localparam int NCOORD     = 6;
    localparam int COORD_IDX_W = $clog2(NCOORD);
    localparam int ACC_W      = 48;
    localparam int COEF_W     = COORD_W + 4;
    localparam int CNT_REG_W  = 5;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    localparam logic [PADDR_W-1:0] ADDR_KEY_COUNT = PADDR_W'(0);

    localparam logic [0:0] FUNC_WRITE = 1'b0;
    localparam logic [0:0] FUNC_EVAL  = 1'b1;

    localparam logic [ACC_W-1:0] ACC_LIM = {1'b0, {(ACC_W-1){1'b1}}};

    typedef logic [NCOORD-1:0][COORD_W-1:0] coord_vec_t;

    typedef struct packed {
        logic [TIME_W-1:0] time_v;
        coord_vec_t        coord;
    } key_t;

    localparam int KEY_W = $bits(key_t);

endpackage

/* rtl/core/kspe_ram.sv */
// ----------------------------------------------------------------------------
// kspe_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kspe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/kspe_div.sv */
// ----------------------------------------------------------------------------
// kspe_div
// Restoring divider for the segment parameter t = (d << FRAC) / e, one
// quotient bit per cycle, with saturation to the Q8 range of t.
// ----------------------------------------------------------------------------
module kspe_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic signed [kspe_pkg::TIME_W:0] num_d,
    input  logic signed [kspe_pkg::TIME_W:0] den_e,
    output logic                            done,
    output logic signed [kspe_pkg::T_W-1:0] t_out,
    output logic                            sat
);
    import kspe_pkg::*;

    localparam int NUM_W = TIME_W + FRAC_BITS;
    localparam int CNT_W = $clog2(NUM_W + 1);
    localparam logic [NUM_W-1:0] QPOS_MAX = NUM_W'((64'(1) << (T_W - 1)) - 64'(1));
    localparam logic [NUM_W-1:0] QNEG_MAX = NUM_W'(64'(1) << (T_W - 1));

    logic              run_reg, run_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [NUM_W-1:0]  num_reg, num_next;
    logic [TIME_W-1:0] den_reg, den_next;
    logic [TIME_W-1:0] rem_reg, rem_next;
    logic              neg_reg, neg_next;
    logic              done_reg, done_next;
    logic [T_W-1:0]    t_reg, t_next;
    logic              sat_reg, sat_next;

    logic [TIME_W-1:0] d_mag, e_mag;
    logic [TIME_W:0]   rem_sh;

    always_comb
    begin
        d_mag = num_d[TIME_W] ? TIME_W'(-num_d) : TIME_W'(num_d);
        e_mag = den_e[TIME_W] ? TIME_W'(-den_e) : TIME_W'(den_e);
        rem_sh = {rem_reg, num_reg[NUM_W-1]};

        run_next  = run_reg;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        neg_next  = neg_reg;
        done_next = 1'b0;
        t_next    = t_reg;
        sat_next  = sat_reg;

        if (start)
        begin
            run_next = 1'b1;
            rem_next = '0;
            den_next = e_mag;
            neg_next = num_d[TIME_W] ^ den_e[TIME_W];
            if (den_e == '0)
            begin
                num_next = NUM_W'(d_mag);
                cnt_next = '0;
            end
            else
            begin
                num_next = {d_mag, FRAC_BITS'(0)};
                cnt_next = CNT_W'(NUM_W);
            end
        end
        else if (run_reg)
        begin
            if (cnt_reg != '0)
            begin
                cnt_next = cnt_reg - CNT_W'(1);
                if (rem_sh >= {1'b0, den_reg})
                begin
                    rem_next = TIME_W'(rem_sh - {1'b0, den_reg});
                    num_next = {num_reg[NUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = TIME_W'(rem_sh);
                    num_next = {num_reg[NUM_W-2:0], 1'b0};
                end
            end
            else
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
                sat_next  = 1'b0;
                if (!neg_reg && num_reg > QPOS_MAX)
                begin
                    t_next   = T_W'(QPOS_MAX);
                    sat_next = 1'b1;
                end
                else if (neg_reg && num_reg > QNEG_MAX)
                begin
                    t_next   = T_W'(-QNEG_MAX);
                    sat_next = 1'b1;
                end
                else if (neg_reg)
                begin
                    t_next = T_W'(-num_reg);
                end
                else
                begin
                    t_next = T_W'(num_reg);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
        t_reg   <= t_next;
        sat_reg <= sat_next;
    end

    assign done  = done_reg;
    assign t_out = $signed(t_reg);
    assign sat   = sat_reg;

endmodule

/* rtl/core/kspe_cubic.sv */
// ----------------------------------------------------------------------------
// kspe_cubic
// Horner evaluation of one spline coordinate with a shared split multiplier:
// low/high partial products, scale and clamp, add and clamp, halve and clamp.
// ----------------------------------------------------------------------------
module kspe_cubic (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [kspe_pkg::COORD_W-1:0] p0,
    input  logic signed [kspe_pkg::COORD_W-1:0] p1,
    input  logic signed [kspe_pkg::COORD_W-1:0] p2,
    input  logic signed [kspe_pkg::T_W-1:0]     t_in,
    output logic                               done,
    output logic signed [kspe_pkg::COORD_W-1:0] res,
    output logic                               sat
);
    import kspe_pkg::*;

    localparam int MLO_W  = 24;
    localparam int MHI_W  = ACC_W - 1 - MLO_W;
    localparam int PROD_W = ACC_W - 1 + T_W;
    localparam int Q_W    = PROD_W - FRAC_BITS;
    localparam int SUM_W  = ACC_W + 1;

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_LO   = 3'd1;
    localparam logic [2:0] PH_HI   = 3'd2;
    localparam logic [2:0] PH_Q    = 3'd3;
    localparam logic [2:0] PH_ADD  = 3'd4;
    localparam logic [2:0] PH_FIN  = 3'd5;

    localparam logic signed [SUM_W-1:0] SUM_HI = SUM_W'(ACC_LIM);
    localparam logic signed [SUM_W-1:0] SUM_LO = -SUM_W'(ACC_LIM);
    localparam logic signed [ACC_W-1:0] HALF_HI = ACC_W'(32'sh7FFF_FFFF);
    localparam logic signed [ACC_W-1:0] HALF_LO = -ACC_W'(33'sh0_8000_0000);

    logic [2:0]                 ph_reg, ph_next;
    logic [1:0]                 step_reg, step_next;
    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    logic signed [COEF_W-1:0]   c2_reg, c2_next;
    logic signed [COEF_W-1:0]   c1_reg, c1_next;
    logic signed [COEF_W-1:0]   c0_reg, c0_next;
    logic [T_W-1:0]             ut_reg, ut_next;
    logic                       tneg_reg, tneg_next;
    logic [MLO_W+T_W-1:0]       plo_reg, plo_next;
    logic [MHI_W+T_W-1:0]       phi_reg, phi_next;
    logic signed [ACC_W-1:0]    qs_reg, qs_next;
    logic                       sat_reg, sat_next;
    logic                       done_reg, done_next;
    logic [COORD_W-1:0]         res_reg, res_next;

    logic signed [COEF_W-1:0]   e0, e1, e2, c3;
    logic [ACC_W-1:0]           ua;
    logic [PROD_W-1:0]          prod;
    logic [Q_W-1:0]             qmag;
    logic [ACC_W-1:0]           qlim;
    logic signed [COEF_W-1:0]   coef;
    logic signed [SUM_W-1:0]    sum;
    logic signed [ACC_W-1:0]    half;

    always_comb
    begin
        e0 = COEF_W'(p0);
        e1 = COEF_W'(p1);
        e2 = COEF_W'(p2);
        c3 = -e0 + 3 * e1 - 2 * e2;
        ua = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
        prod = {phi_reg, MLO_W'(0)} + PROD_W'(plo_reg);
        qmag = prod[PROD_W-1:FRAC_BITS];
        qlim = (qmag > Q_W'(ACC_LIM)) ? ACC_LIM : ACC_W'(qmag);
        unique case (step_reg)
            2'd0:    coef = c2_reg;
            2'd1:    coef = c1_reg;
            default: coef = c0_reg;
        endcase
        sum  = SUM_W'(qs_reg) + SUM_W'(coef);
        half = (acc_reg + $signed(ACC_W'(acc_reg[ACC_W-1]))) >>> 1;

        ph_next   = ph_reg;
        step_next = step_reg;
        acc_next  = acc_reg;
        c2_next   = c2_reg;
        c1_next   = c1_reg;
        c0_next   = c0_reg;
        ut_next   = ut_reg;
        tneg_next = tneg_reg;
        plo_next  = plo_reg;
        phi_next  = phi_reg;
        qs_next   = qs_reg;
        sat_next  = sat_reg;
        done_next = 1'b0;
        res_next  = res_reg;

        unique case (ph_reg)
            PH_IDLE:
            begin
                if (start)
                begin
                    acc_next  = ACC_W'(c3);
                    c2_next   = 2 * e0 - 5 * e1 + 3 * e2;
                    c1_next   = e2 - e0;
                    c0_next   = 2 * e1;
                    ut_next   = t_in[T_W-1] ? T_W'(-t_in) : T_W'(t_in);
                    tneg_next = t_in[T_W-1];
                    step_next = 2'd0;
                    sat_next  = 1'b0;
                    ph_next   = PH_LO;
                end
            end
            PH_LO:
            begin
                plo_next = ua[MLO_W-1:0] * ut_reg;
                ph_next  = PH_HI;
            end
            PH_HI:
            begin
                phi_next = ua[ACC_W-2:MLO_W] * ut_reg;
                ph_next  = PH_Q;
            end
            PH_Q:
            begin
                if (qmag > Q_W'(ACC_LIM))
                begin
                    sat_next = 1'b1;
                end
                qs_next = (acc_reg[ACC_W-1] ^ tneg_reg) ? -$signed(qlim) : $signed(qlim);
                ph_next = PH_ADD;
            end
            PH_ADD:
            begin
                if (sum > SUM_HI)
                begin
                    acc_next = ACC_W'(SUM_HI);
                    sat_next = 1'b1;
                end
                else if (sum < SUM_LO)
                begin
                    acc_next = ACC_W'(SUM_LO);
                    sat_next = 1'b1;
                end
                else
                begin
                    acc_next = ACC_W'(sum);
                end
                step_next = step_reg + 2'd1;
                ph_next   = (step_reg == 2'd2) ? PH_FIN : PH_LO;
            end
            PH_FIN:
            begin
                if (half > HALF_HI)
                begin
                    res_next = COORD_W'(HALF_HI);
                    sat_next = 1'b1;
                end
                else if (half < HALF_LO)
                begin
                    res_next = COORD_W'(HALF_LO);
                    sat_next = 1'b1;
                end
                else
                begin
                    res_next = COORD_W'(half);
                end
                done_next = 1'b1;
                ph_next   = PH_IDLE;
            end
            default:
            begin
                ph_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg   <= PH_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            ph_reg   <= ph_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        acc_reg  <= acc_next;
        c2_reg   <= c2_next;
        c1_reg   <= c1_next;
        c0_reg   <= c0_next;
        ut_reg   <= ut_next;
        tneg_reg <= tneg_next;
        plo_reg  <= plo_next;
        phi_reg  <= phi_next;
        qs_reg   <= qs_next;
        sat_reg  <= sat_next;
        res_reg  <= res_next;
    end

    assign done = done_reg;
    assign res  = $signed(res_reg);
    assign sat  = sat_reg;

endmodule

/* rtl/core/keyframe_spline_path_eval.sv */
// ----------------------------------------------------------------------------
// keyframe_spline_path_eval
// Keyframe camera-path evaluator: keyframe store in RAM, linear key search,
// serial divide for t and a shared Horner unit for the six coordinates.
//
//   channel  signals                               transfer when
//   in       in_valid/in_ready, func..in_look_z    in_valid && in_ready
//   out      out_valid/out_ready, out_pos_x..sat.  out_valid && out_ready
//   cfg      psel/penable/pwrite/paddr/pwdata      psel && penable && pwrite
//
// Write item: the key RAM is written at the transfer.
// Evaluate: each key read in the search goes through the registered RAM read,
// then the serial divider runs, then the Horner unit once per coordinate.
// One item at a time; in_ready is high only when the sequencer is idle.
// A finished result waits in the output register while the next item enters.
// Reset clears state, key count, out_valid and last result, not the key RAM.
// ----------------------------------------------------------------------------
module keyframe_spline_path_eval (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               func,
    input  logic [3:0]                         key_index,
    input  logic [kspe_pkg::TIME_W-1:0]         time_value,
    input  logic signed [kspe_pkg::COORD_W-1:0] in_pos_x,
    input  logic signed [kspe_pkg::COORD_W-1:0] in_pos_y,
    input  logic signed [kspe_pkg::COORD_W-1:0] in_pos_z,
    input  logic signed [kspe_pkg::COORD_W-1:0] in_look_x,
    input  logic signed [kspe_pkg::COORD_W-1:0] in_look_y,
    input  logic signed [kspe_pkg::COORD_W-1:0] in_look_z,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [kspe_pkg::COORD_W-1:0] out_pos_x,
    output logic signed [kspe_pkg::COORD_W-1:0] out_pos_y,
    output logic signed [kspe_pkg::COORD_W-1:0] out_pos_z,
    output logic signed [kspe_pkg::COORD_W-1:0] out_look_x,
    output logic signed [kspe_pkg::COORD_W-1:0] out_look_y,
    output logic signed [kspe_pkg::COORD_W-1:0] out_look_z,
    output logic                               held,
    output logic                               few_keys,
    output logic                               saturated,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [kspe_pkg::PADDR_W-1:0]        paddr,
    input  logic [kspe_pkg::PDATA_W-1:0]        pwdata,
    output logic [kspe_pkg::PDATA_W-1:0]        prdata,
    output logic                               pready
);
    import kspe_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD   = 4'd1;
    localparam logic [3:0] S_CHK  = 4'd2;
    localparam logic [3:0] S_RDN  = 4'd3;
    localparam logic [3:0] S_GETN = 4'd4;
    localparam logic [3:0] S_DIV  = 4'd5;
    localparam logic [3:0] S_DIVW = 4'd6;
    localparam logic [3:0] S_CUB  = 4'd7;
    localparam logic [3:0] S_CUBW = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;

    logic [3:0]             state_reg, state_next;
    logic [CNT_REG_W-1:0]   count_reg, count_next;
    logic [KEY_CNT_W-1:0]   n_reg, n_next;
    logic [KEY_IDX_W-1:0]   idx_reg, idx_next;
    logic [TIME_W-1:0]      query_reg, query_next;
    key_t                   prev_reg, prev_next;
    key_t                   cur_reg, cur_next;
    key_t                   nxt_reg, nxt_next;
    logic                   few_reg, few_next;
    logic                   held_reg, held_next;
    logic                   sat_reg, sat_next;
    logic [T_W-1:0]         t_reg, t_next;
    logic [COORD_IDX_W-1:0] cidx_reg, cidx_next;
    coord_vec_t             res_reg, res_next;
    coord_vec_t             last_reg, last_next;
    logic                   out_valid_reg, out_valid_next;
    coord_vec_t             out_coord_reg, out_coord_next;
    logic                   out_held_reg, out_held_next;
    logic                   out_few_reg, out_few_next;
    logic                   out_sat_reg, out_sat_next;

    logic                   in_xfer, cfg_wr;
    logic                   ram_we;
    key_t                   ram_wdata, ram_rdata;
    logic [KEY_W-1:0]       ram_rbits;
    logic [KEY_CNT_W-1:0]   n_in;
    logic [KEY_CNT_W-1:0]   idx_ext;
    logic                   div_start, div_done, div_sat;
    logic signed [T_W-1:0]  div_t;
    logic signed [TIME_W:0] div_d, div_e;
    logic                   cub_start, cub_done, cub_sat;
    logic signed [COORD_W-1:0] cub_res;

    assign in_ready = (state_reg == S_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign cfg_wr   = psel && penable && pwrite && (paddr == ADDR_KEY_COUNT);
    assign pready   = 1'b1;
    assign prdata   = (paddr == ADDR_KEY_COUNT) ? PDATA_W'(count_reg) : '0;

    assign ram_we = in_xfer && (func == FUNC_WRITE) && (32'(key_index) < 32'(MAX_KEYS));
    assign ram_wdata.time_v = time_value;
    assign ram_wdata.coord  = {in_look_z, in_look_y, in_look_x, in_pos_z, in_pos_y, in_pos_x};
    assign ram_rdata = key_t'(ram_rbits);

    kspe_ram #(
        .WIDTH (KEY_W),
        .DEPTH (MAX_KEYS)
    ) u_key_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (KEY_IDX_W'(key_index)),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (ram_rbits)
    );

    assign div_start = (state_reg == S_DIV);
    assign div_d = $signed({1'b0, query_reg}) - $signed({1'b0, prev_reg.time_v});
    assign div_e = $signed({1'b0, cur_reg.time_v}) - $signed({1'b0, prev_reg.time_v});

    kspe_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num_d (div_d),
        .den_e (div_e),
        .done  (div_done),
        .t_out (div_t),
        .sat   (div_sat)
    );

    assign cub_start = (state_reg == S_CUB);

    kspe_cubic u_cubic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cub_start),
        .p0    ($signed(prev_reg.coord[cidx_reg])),
        .p1    ($signed(cur_reg.coord[cidx_reg])),
        .p2    ($signed(nxt_reg.coord[cidx_reg])),
        .t_in  ($signed(t_reg)),
        .done  (cub_done),
        .res   (cub_res),
        .sat   (cub_sat)
    );

    always_comb
    begin
        n_in = (32'(count_reg) > 32'(MAX_KEYS)) ? KEY_CNT_W'(MAX_KEYS)
                                                : KEY_CNT_W'(count_reg);
        idx_ext = KEY_CNT_W'(idx_reg);

        state_next     = state_reg;
        count_next     = cfg_wr ? CNT_REG_W'(pwdata) : count_reg;
        n_next         = n_reg;
        idx_next       = idx_reg;
        query_next     = query_reg;
        prev_next      = prev_reg;
        cur_next       = cur_reg;
        nxt_next       = nxt_reg;
        few_next       = few_reg;
        held_next      = held_reg;
        sat_next       = sat_reg;
        t_next         = t_reg;
        cidx_next      = cidx_reg;
        res_next       = res_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_coord_next = out_coord_reg;
        out_held_next  = out_held_reg;
        out_few_next   = out_few_reg;
        out_sat_next   = out_sat_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer && func == FUNC_EVAL)
                begin
                    query_next = time_value;
                    n_next     = n_in;
                    few_next   = (n_in < KEY_CNT_W'(MIN_KEYS));
                    held_next  = 1'b0;
                    sat_next   = 1'b0;
                    idx_next   = '0;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (few_reg)
                begin
                    res_next   = ram_rdata.coord;
                    state_next = S_OUT;
                end
                else if (idx_reg == '0)
                begin
                    prev_next  = ram_rdata;
                    idx_next   = idx_reg + KEY_IDX_W'(1);
                    state_next = S_RD;
                end
                else if (idx_ext + KEY_CNT_W'(1) >= n_reg)
                begin
                    held_next  = 1'b1;
                    res_next   = last_reg;
                    state_next = S_OUT;
                end
                else if (ram_rdata.time_v < query_reg)
                begin
                    prev_next  = ram_rdata;
                    idx_next   = idx_reg + KEY_IDX_W'(1);
                    state_next = S_RD;
                end
                else
                begin
                    cur_next   = ram_rdata;
                    idx_next   = idx_reg + KEY_IDX_W'(1);
                    state_next = S_RDN;
                end
            end
            S_RDN:
            begin
                state_next = S_GETN;
            end
            S_GETN:
            begin
                nxt_next   = ram_rdata;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                state_next = S_DIVW;
            end
            S_DIVW:
            begin
                if (div_done)
                begin
                    t_next     = div_t;
                    sat_next   = sat_reg | div_sat;
                    cidx_next  = '0;
                    state_next = S_CUB;
                end
            end
            S_CUB:
            begin
                state_next = S_CUBW;
            end
            S_CUBW:
            begin
                if (cub_done)
                begin
                    res_next[cidx_reg] = cub_res;
                    sat_next = sat_reg | cub_sat;
                    if (cidx_reg == COORD_IDX_W'(NCOORD - 1))
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        cidx_next  = cidx_reg + COORD_IDX_W'(1);
                        state_next = S_CUB;
                    end
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_coord_next = res_reg;
                    out_held_next  = held_reg;
                    out_few_next   = few_reg;
                    out_sat_next   = !held_reg && !few_reg && sat_reg;
                    if (!held_reg)
                    begin
                        last_next = res_reg;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg         <= n_next;
        idx_reg       <= idx_next;
        query_reg     <= query_next;
        prev_reg      <= prev_next;
        cur_reg       <= cur_next;
        nxt_reg       <= nxt_next;
        few_reg       <= few_next;
        held_reg      <= held_next;
        sat_reg       <= sat_next;
        t_reg         <= t_next;
        cidx_reg      <= cidx_next;
        res_reg       <= res_next;
        out_coord_reg <= out_coord_next;
        out_held_reg  <= out_held_next;
        out_few_reg   <= out_few_next;
        out_sat_reg   <= out_sat_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_pos_x  = $signed(out_coord_reg[0]);
    assign out_pos_y  = $signed(out_coord_reg[1]);
    assign out_pos_z  = $signed(out_coord_reg[2]);
    assign out_look_x = $signed(out_coord_reg[3]);
    assign out_look_y = $signed(out_coord_reg[4]);
    assign out_look_z = $signed(out_coord_reg[5]);
    assign held       = out_held_reg;
    assign few_keys   = out_few_reg;
    assign saturated  = out_sat_reg;

endmodule

/* rtl/core/kspe_chk.sv */
// ----------------------------------------------------------------------------
// kspe_chk
// Port-level checker for the keyframe spline path evaluator.
// ----------------------------------------------------------------------------
module kspe_chk (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_ready,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic signed [kspe_pkg::COORD_W-1:0] out_pos_x,
    input logic signed [kspe_pkg::COORD_W-1:0] out_look_z,
    input logic                               held,
    input logic                               few_keys,
    input logic                               saturated
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_pos_x) && $stable(out_look_z))
        else $error("result changed while stalled");

    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(held && few_keys))
        else $error("held and few_keys both set");

    a_sat_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (held || few_keys) |-> !saturated)
        else $error("saturated flagged on a held or few-key result");

    a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result appeared one cycle after an input transfer");

endmodule

bind keyframe_spline_path_eval kspe_chk u_kspe_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_pos_x  (out_pos_x),
    .out_look_z (out_look_z),
    .held       (held),
    .few_keys   (few_keys),
    .saturated  (saturated)
);
